/* hw/rtl/relative_range_bearing_unit_defines.svh */
// ---------------------------------------------------------------------------
// Relative range and bearing unit: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RELATIVE_RANGE_BEARING_UNIT_DEFINES_SVH
`define RELATIVE_RANGE_BEARING_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rrb_pkg.sv */
// ---------------------------------------------------------------------------
// rrb_pkg
// Types, constants and the arctangent step table of the range/bearing unit.
// ---------------------------------------------------------------------------
`default_nettype none

package rrb_pkg;

    localparam int POSITION_BITS        = 24;
    localparam int CORDIC_STEPS_DEFAULT = 16;
    localparam int FRAC_SHIFT           = 8;
    // Pre-scaled difference plus headroom for the CORDIC gain and sign.
    localparam int WORK_BITS            = POSITION_BITS + 12;
    localparam int ANGLE_BITS           = 32;
    localparam int HEADING_BITS         = 16;
    localparam int RANGE_BITS           = 25;
    localparam int SPLIT_BITS           = 20;
    localparam int ROUND_SHIFT          = 40;
    localparam int GAIN_BITS            = 32;

    localparam logic [GAIN_BITS-1:0]  INV_GAIN   = 32'd2608131496;
    localparam logic [ANGLE_BITS-1:0] ANGLE_PI   = 32'h8000_0000;
    localparam logic [ANGLE_BITS-1:0] ANGLE_HALF = 32'h0000_8000;

    typedef struct packed {
        logic signed [POSITION_BITS-1:0] observer_x;
        logic signed [POSITION_BITS-1:0] observer_y;
        logic signed [HEADING_BITS-1:0]  observer_heading;
        logic signed [POSITION_BITS-1:0] target_x;
        logic signed [POSITION_BITS-1:0] target_y;
    } query_t;

    typedef struct packed {
        logic [RANGE_BITS-1:0]          range;
        logic signed [HEADING_BITS-1:0] bearing;
    } result_t;

    typedef struct packed {
        logic signed [WORK_BITS-1:0] x;
        logic signed [WORK_BITS-1:0] y;
        logic [ANGLE_BITS-1:0]       z;
        logic                        zero;
        logic [HEADING_BITS-1:0]     heading;
    } cordic_word_t;

    // round(atan(2^-i) * 2^32 / (2*pi))
    function automatic logic [ANGLE_BITS-1:0] atan_step(input int unsigned idx);
        logic [ANGLE_BITS-1:0] t;
        case (idx)
            0:       t = 32'd536870912;
            1:       t = 32'd316933406;
            2:       t = 32'd167458907;
            3:       t = 32'd85004756;
            4:       t = 32'd42667331;
            5:       t = 32'd21354465;
            6:       t = 32'd10679838;
            7:       t = 32'd5340245;
            8:       t = 32'd2670163;
            9:       t = 32'd1335087;
            10:      t = 32'd667544;
            11:      t = 32'd333772;
            12:      t = 32'd166886;
            13:      t = 32'd83443;
            14:      t = 32'd41722;
            15:      t = 32'd20861;
            16:      t = 32'd10430;
            17:      t = 32'd5215;
            18:      t = 32'd2608;
            19:      t = 32'd1304;
            20:      t = 32'd652;
            21:      t = 32'd326;
            22:      t = 32'd163;
            23:      t = 32'd81;
            24:      t = 32'd41;
            25:      t = 32'd20;
            26:      t = 32'd10;
            27:      t = 32'd5;
            28:      t = 32'd3;
            29:      t = 32'd1;
            30:      t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/relative_range_bearing_unit.sv */
// ---------------------------------------------------------------------------
// relative_range_bearing_unit
// Range and relative bearing from an observer to a target by CORDIC.
// ---------------------------------------------------------------------------
// A query word is taken on every clock where start is high; busy never rises,
// so queries may follow each other on every cycle. Each query produces one
// result word, shown for one cycle with done high; the receiver must take it
// then. The pipeline holds one register for the offset, one register per CORDIC
// micro-rotation, and two for the gain multiply and rounding. The bearing is
// the heading minus atan2 of the offset, as a 16-bit binary angle in
// [-pi, pi); an observer on the target gives range zero and its own heading.
// ---------------------------------------------------------------------------
`default_nettype none
`include "relative_range_bearing_unit_defines.svh"

module relative_range_bearing_unit
    import rrb_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    output logic        busy,
    input  wire query_t query,
    output logic        done,
    output result_t     result
);

    localparam int Latency = CORDIC_STEPS + 3;

    logic         stage_valid [CORDIC_STEPS+1];
    cordic_word_t stage_word  [CORDIC_STEPS+1];
    logic         accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    rrb_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .query     (query),
        .out_valid (stage_valid[0]),
        .out_word  (stage_word[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_stage
        rrb_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_word   (stage_word[i]),
            .out_valid (stage_valid[i+1]),
            .out_word  (stage_word[i+1])
        );
    end

    rrb_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stage_valid[CORDIC_STEPS]),
        .in_word    (stage_word[CORDIC_STEPS]),
        .out_valid  (done),
        .out_result (result)
    );

    `RRB_ASSERT_NEXT(a_accept_enters, accept, stage_valid[0],
        "Accepted query word did not enter the pipeline.")

    `RRB_ASSERT_NOW(a_done_has_source, done, $past(accept, Latency),
        "Result word without a matching query word.")

    `RRB_ASSERT_NOW(a_same_point,
        done && $past(accept && (query.observer_x == query.target_x)
                      && (query.observer_y == query.target_y), Latency),
        (result.range == '0) && (result.bearing == $past(query.observer_heading, Latency)),
        "Observer on target must give zero range and its own heading.")

    `RRB_ASSERT_NOW(a_zero_vector, stage_valid[0] && stage_word[0].zero,
        (stage_word[0].x == '0) && (stage_word[0].y == '0),
        "Zero flag set on a nonzero offset.")

    `RRB_ASSERT_NOW(a_right_half, stage_valid[0],
        !stage_word[0].x[WORK_BITS-1],
        "Offset was not folded into the right half plane.")

endmodule

`default_nettype wire

/* hw/rtl/rrb_prep.sv */
// ---------------------------------------------------------------------------
// rrb_prep
// Forms the target offset, folds it into the right half plane and scales it.
// ---------------------------------------------------------------------------
`default_nettype none

module rrb_prep
    import rrb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire query_t       query,
    output logic              out_valid,
    output cordic_word_t      out_word
);

    logic         valid_reg;
    logic         valid_next;
    cordic_word_t word_reg;
    cordic_word_t word_next;

    logic signed [WORK_BITS-1:0] dx;
    logic signed [WORK_BITS-1:0] dy;
    logic signed [WORK_BITS-1:0] fx;
    logic signed [WORK_BITS-1:0] fy;
    logic                        flip;

    always_comb
    begin
        // y grows downward, so the vertical offset is observer minus target.
        dx   = WORK_BITS'(query.target_x) - WORK_BITS'(query.observer_x);
        dy   = WORK_BITS'(query.observer_y) - WORK_BITS'(query.target_y);
        flip = dx[WORK_BITS-1];
        fx   = flip ? -dx : dx;
        fy   = flip ? -dy : dy;

        valid_next        = in_valid;
        word_next.x       = fx <<< FRAC_SHIFT;
        word_next.y       = fy <<< FRAC_SHIFT;
        word_next.z       = flip ? ANGLE_PI : '0;
        word_next.zero    = (dx == '0) && (dy == '0);
        word_next.heading = query.observer_heading;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

/* hw/rtl/rrb_cordic_stage.sv */
// ---------------------------------------------------------------------------
// rrb_cordic_stage
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// ---------------------------------------------------------------------------
`default_nettype none

module rrb_cordic_stage
    import rrb_pkg::*;
#(
    parameter int unsigned STEP = 0
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire cordic_word_t in_word,
    output logic              out_valid,
    output cordic_word_t      out_word
);

    localparam logic [ANGLE_BITS-1:0] StepAngle = atan_step(STEP);

    logic         valid_reg;
    logic         valid_next;
    cordic_word_t word_reg;
    cordic_word_t word_next;

    logic signed [WORK_BITS-1:0] xs;
    logic signed [WORK_BITS-1:0] ys;
    logic                        rot_down;

    always_comb
    begin
        xs       = $signed(in_word.x) >>> STEP;
        ys       = $signed(in_word.y) >>> STEP;
        rot_down = !in_word.y[WORK_BITS-1];

        word_next = in_word;
        if (rot_down)
        begin
            word_next.x = in_word.x + ys;
            word_next.y = in_word.y - xs;
            word_next.z = in_word.z + StepAngle;
        end
        else
        begin
            word_next.x = in_word.x - ys;
            word_next.y = in_word.y + xs;
            word_next.z = in_word.z - StepAngle;
        end
        valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

/* hw/rtl/rrb_scale.sv */
// ---------------------------------------------------------------------------
// rrb_scale
// Removes the CORDIC gain from the magnitude and forms the relative bearing.
// ---------------------------------------------------------------------------
`default_nettype none

module rrb_scale
    import rrb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire cordic_word_t in_word,
    output logic              out_valid,
    output result_t           out_result
);

    localparam int HiBits     = WORK_BITS - 1 - SPLIT_BITS;
    localparam int HiProdBits = HiBits + GAIN_BITS;
    localparam int LoProdBits = SPLIT_BITS + GAIN_BITS;
    localparam int SumBits    = HiProdBits + SPLIT_BITS + 1;
    localparam int FullBits   = SumBits - ROUND_SHIFT;

    // Product stage
    logic                    prod_valid_reg;
    logic                    prod_valid_next;
    logic [HiProdBits-1:0]   hi_prod_reg;
    logic [HiProdBits-1:0]   hi_prod_next;
    logic [LoProdBits-1:0]   lo_prod_reg;
    logic [LoProdBits-1:0]   lo_prod_next;
    logic [HEADING_BITS-1:0] bearing_reg;
    logic [HEADING_BITS-1:0] bearing_next;

    // Output stage
    logic    res_valid_reg;
    logic    res_valid_next;
    result_t res_reg;
    result_t res_next;

    logic [WORK_BITS-2:0]    mag;
    logic [ANGLE_BITS-1:0]   angle_rnd;
    logic [SumBits-1:0]      sum;
    logic [FullBits-1:0]     full;

    always_comb
    begin
        mag          = in_word.x[WORK_BITS-1] ? '0 : in_word.x[WORK_BITS-2:0];
        hi_prod_next = HiProdBits'(mag[WORK_BITS-2:SPLIT_BITS]) * HiProdBits'(INV_GAIN);
        lo_prod_next = LoProdBits'(mag[SPLIT_BITS-1:0]) * LoProdBits'(INV_GAIN);
        angle_rnd    = in_word.z + ANGLE_HALF;
        // With the observer on the target the direction counts as zero.
        bearing_next = in_word.zero ? in_word.heading
                                    : in_word.heading - angle_rnd[ANGLE_BITS-1:16];
        prod_valid_next = in_valid;
    end

    always_comb
    begin
        sum  = (SumBits'(hi_prod_reg) << SPLIT_BITS) + SumBits'(lo_prod_reg)
             + (SumBits'(1) << (ROUND_SHIFT - 1));
        full = sum[SumBits-1:ROUND_SHIFT];
        res_next.range   = (|full[FullBits-1:RANGE_BITS]) ? '1 : full[RANGE_BITS-1:0];
        res_next.bearing = bearing_reg;
        res_valid_next   = prod_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_prod_reg <= hi_prod_next;
        lo_prod_reg <= lo_prod_next;
        bearing_reg <= bearing_next;
        res_reg     <= res_next;
    end

    assign out_valid  = res_valid_reg;
    assign out_result = res_reg;

endmodule

`default_nettype wire
